@@ sv/dmfp_pkg.sv @@
// ----------------------------------------------------------------------------
// dmfp_pkg
// Shared types and constants for the DNS message field parser.
// ----------------------------------------------------------------------------
package dmfp_pkg;

    localparam int MsgMaxDefault = 1024;

    typedef enum logic [4:0] {
        TK_ID       = 5'd0,
        TK_FLAGS    = 5'd1,
        TK_QDCOUNT  = 5'd2,
        TK_ANCOUNT  = 5'd3,
        TK_NSCOUNT  = 5'd4,
        TK_ARCOUNT  = 5'd5,
        TK_LABELLEN = 5'd6,
        TK_CHAR     = 5'd7,
        TK_POINTER  = 5'd8,
        TK_NAMEEND  = 5'd9,
        TK_TYPE     = 5'd10,
        TK_CLASS    = 5'd11,
        TK_TTL      = 5'd12,
        TK_RDLEN    = 5'd13,
        TK_RDATA    = 5'd14,
        TK_MXPREF   = 5'd15,
        TK_END      = 5'd16,
        TK_ERROR    = 5'd17
    } token_kind_t;

    typedef enum logic [4:0] {
        PH_HDR    = 5'd0,
        PH_QN_LEN = 5'd1,
        PH_QN_CHR = 5'd2,
        PH_QN_PTR = 5'd3,
        PH_RN_LEN = 5'd4,
        PH_RN_CHR = 5'd5,
        PH_RN_PTR = 5'd6,
        PH_DN_LEN = 5'd7,
        PH_DN_CHR = 5'd8,
        PH_DN_PTR = 5'd9,
        PH_QTYPE  = 5'd10,
        PH_QCLASS = 5'd11,
        PH_RTYPE  = 5'd12,
        PH_RCLASS = 5'd13,
        PH_TTL    = 5'd14,
        PH_RDLEN  = 5'd15,
        PH_MXPREF = 5'd16,
        PH_RDRAW  = 5'd17,
        PH_TRAIL  = 5'd18
    } phase_t;

    localparam logic [31:0] ErrTooShort  = 32'd0;
    localparam logic [31:0] ErrTruncated = 32'd1;
    localparam logic [15:0] TypeMx       = 16'd15;
    localparam logic [15:0] TypeCname    = 16'd5;

    typedef struct packed {
        token_kind_t kind;
        logic [31:0] value;
        logic [17:0] rec;
        logic [1:0]  sec;
        logic [9:0]  off;
    } token_t;

    typedef struct packed {
        phase_t      phase;
        logic [9:0]  pos;
        logic [31:0] acc;
        logic [2:0]  fbl;
        logic [15:0] qleft;
        logic [17:0] rleft;
        logic [17:0] rcnt;
        logic [7:0]  lbl;
        logic [15:0] rtype;
        logic [15:0] rdleft;
        logic        stopped;
        logic [9:0]  leftover;
    } pstate_t;

endpackage

@@ sv/dmfp_step.sv @@
// ----------------------------------------------------------------------------
// dmfp_step
// Combinational parse step: one message byte against the parse state,
// giving the next state and up to two tokens.
// ----------------------------------------------------------------------------
module dmfp_step #(
    parameter logic [9:0] PosCap = 10'd1023
) (
    input  dmfp_pkg::pstate_t st,
    input  logic [7:0]        b,
    input  logic              last,
    output dmfp_pkg::pstate_t nx,
    output logic [1:0]        n,
    output dmfp_pkg::token_t  t0,
    output dmfp_pkg::token_t  t1
);

    always_comb begin
        dmfp_pkg::token_t tk;
        logic        in_rd;
        logic        stop_now;
        logic        have;
        logic [15:0] v16;
        logic [31:0] acc_sh;
        logic [2:0]  fbl_d;
        logic [1:0]  ctx;
        logic [1:0]  sec;
        logic [15:0] rdl;
        logic [7:0]  lbl_d;
        logic [17:0] rl;

        nx       = st;
        tk       = '0;
        have     = 1'b0;
        in_rd    = 1'b0;
        stop_now = 1'b0;
        v16      = {st.acc[7:0], b};
        acc_sh   = {st.acc[23:0], b};
        fbl_d    = (st.fbl != 3'd0) ? st.fbl - 3'd1 : 3'd0;
        rdl      = (st.rdleft != 16'd0) ? st.rdleft - 16'd1 : 16'd0;
        lbl_d    = (st.lbl != 8'd0) ? st.lbl - 8'd1 : 8'd0;
        ctx      = 2'd0;
        sec      = 2'd1;
        rl       = 18'd0;
        tk.rec   = st.rcnt;
        tk.off   = st.pos;

        if (!st.stopped) begin
            case (st.phase)
                dmfp_pkg::PH_HDR: begin
                    if (!st.pos[0]) begin
                        nx.acc = {24'd0, b};
                    end else begin
                        have     = 1'b1;
                        tk.value = {16'd0, v16};
                        tk.rec   = '0;
                        tk.sec   = 2'd0;
                        if (st.pos == 10'd1) begin
                            tk.kind = dmfp_pkg::TK_ID;
                        end else if (st.pos == 10'd3) begin
                            tk.kind = dmfp_pkg::TK_FLAGS;
                            if (st.acc[7] && (b[2:0] != 3'd0)) begin
                                nx.stopped = 1'b1;
                                stop_now   = 1'b1;
                            end
                        end else begin
                            case (st.pos[3:0])
                                4'd5:    tk.kind = dmfp_pkg::TK_QDCOUNT;
                                4'd7:    tk.kind = dmfp_pkg::TK_ANCOUNT;
                                4'd9:    tk.kind = dmfp_pkg::TK_NSCOUNT;
                                default: tk.kind = dmfp_pkg::TK_ARCOUNT;
                            endcase
                            rl = st.rleft + {2'd0, v16};
                            if (st.pos == 10'd5) nx.qleft = v16;
                            else nx.rleft = rl;
                            if (st.pos == 10'd11) begin
                                nx.rcnt = '0;
                                if (st.qleft != 16'd0) nx.phase = dmfp_pkg::PH_QN_LEN;
                                else if (rl != 18'd0) nx.phase = dmfp_pkg::PH_RN_LEN;
                                else nx.phase = dmfp_pkg::PH_TRAIL;
                            end
                        end
                    end
                end
                dmfp_pkg::PH_QN_LEN, dmfp_pkg::PH_QN_CHR, dmfp_pkg::PH_QN_PTR,
                dmfp_pkg::PH_RN_LEN, dmfp_pkg::PH_RN_CHR, dmfp_pkg::PH_RN_PTR,
                dmfp_pkg::PH_DN_LEN, dmfp_pkg::PH_DN_CHR, dmfp_pkg::PH_DN_PTR: begin
                    if (st.phase >= dmfp_pkg::PH_DN_LEN) ctx = 2'd2;
                    else if (st.phase >= dmfp_pkg::PH_RN_LEN) ctx = 2'd1;
                    sec = ctx + 2'd1;
                    tk.sec = sec;
                    if (ctx == 2'd2) begin
                        in_rd     = 1'b1;
                        nx.rdleft = rdl;
                    end
                    // decode label length, character or pointer
                    if (st.phase == dmfp_pkg::PH_QN_LEN || st.phase == dmfp_pkg::PH_RN_LEN
                        || st.phase == dmfp_pkg::PH_DN_LEN) begin
                        if (b[7:6] == 2'b11) begin
                            nx.acc   = {26'd0, b[5:0]};
                            nx.phase = dmfp_pkg::phase_t'(st.phase + 5'd2);
                        end else if (b == 8'd0) begin
                            have     = 1'b1;
                            tk.kind  = dmfp_pkg::TK_NAMEEND;
                            tk.value = '0;
                        end else begin
                            have     = 1'b1;
                            tk.kind  = dmfp_pkg::TK_LABELLEN;
                            tk.value = {24'd0, b};
                            nx.lbl   = b;
                            nx.phase = dmfp_pkg::phase_t'(st.phase + 5'd1);
                        end
                    end else if (st.phase == dmfp_pkg::PH_QN_CHR
                                 || st.phase == dmfp_pkg::PH_RN_CHR
                                 || st.phase == dmfp_pkg::PH_DN_CHR) begin
                        have     = 1'b1;
                        tk.kind  = dmfp_pkg::TK_CHAR;
                        tk.value = {24'd0, b};
                        nx.lbl   = lbl_d;
                        if (lbl_d == 8'd0) nx.phase = dmfp_pkg::phase_t'(st.phase - 5'd1);
                    end else begin
                        have     = 1'b1;
                        tk.kind  = dmfp_pkg::TK_POINTER;
                        tk.value = {18'd0, st.acc[5:0], b};
                    end
                    // name finished: move to the field after it
                    if (have && (tk.kind == dmfp_pkg::TK_NAMEEND
                                 || tk.kind == dmfp_pkg::TK_POINTER)) begin
                        if (ctx == 2'd0) begin
                            nx.phase = dmfp_pkg::PH_QTYPE;
                            nx.fbl   = 3'd2;
                            nx.acc   = '0;
                        end else if (ctx == 2'd1) begin
                            nx.phase = dmfp_pkg::PH_RTYPE;
                            nx.fbl   = 3'd2;
                            nx.acc   = '0;
                        end else begin
                            nx.phase = dmfp_pkg::PH_RDRAW;
                        end
                    end
                end
                dmfp_pkg::PH_QTYPE, dmfp_pkg::PH_QCLASS, dmfp_pkg::PH_RTYPE,
                dmfp_pkg::PH_RCLASS, dmfp_pkg::PH_TTL, dmfp_pkg::PH_RDLEN,
                dmfp_pkg::PH_MXPREF: begin
                    if (st.phase == dmfp_pkg::PH_MXPREF) begin
                        in_rd     = 1'b1;
                        nx.rdleft = rdl;
                    end
                    nx.acc = acc_sh;
                    nx.fbl = fbl_d;
                    v16    = acc_sh[15:0];
                    tk.sec = 2'd2;
                    if (fbl_d == 3'd0) begin
                        have     = 1'b1;
                        tk.value = {16'd0, v16};
                        case (st.phase)
                            dmfp_pkg::PH_QTYPE: begin
                                tk.kind  = dmfp_pkg::TK_TYPE;
                                tk.sec   = 2'd1;
                                nx.phase = dmfp_pkg::PH_QCLASS;
                                nx.fbl   = 3'd2;
                                nx.acc   = '0;
                            end
                            dmfp_pkg::PH_QCLASS: begin
                                tk.kind = dmfp_pkg::TK_CLASS;
                                tk.sec  = 2'd1;
                                nx.qleft = (st.qleft != 16'd0) ? st.qleft - 16'd1 : 16'd0;
                                nx.rcnt  = st.rcnt + 18'd1;
                                if (nx.qleft != 16'd0) begin
                                    nx.phase = dmfp_pkg::PH_QN_LEN;
                                end else begin
                                    nx.rcnt  = '0;
                                    nx.phase = (st.rleft != 18'd0) ? dmfp_pkg::PH_RN_LEN
                                                                   : dmfp_pkg::PH_TRAIL;
                                end
                            end
                            dmfp_pkg::PH_RTYPE: begin
                                tk.kind  = dmfp_pkg::TK_TYPE;
                                nx.rtype = v16;
                                nx.phase = dmfp_pkg::PH_RCLASS;
                                nx.fbl   = 3'd2;
                                nx.acc   = '0;
                            end
                            dmfp_pkg::PH_RCLASS: begin
                                tk.kind  = dmfp_pkg::TK_CLASS;
                                nx.phase = dmfp_pkg::PH_TTL;
                                nx.fbl   = 3'd4;
                                nx.acc   = '0;
                            end
                            dmfp_pkg::PH_TTL: begin
                                tk.kind  = dmfp_pkg::TK_TTL;
                                tk.value = acc_sh;
                                nx.phase = dmfp_pkg::PH_RDLEN;
                                nx.fbl   = 3'd2;
                                nx.acc   = '0;
                            end
                            dmfp_pkg::PH_RDLEN: begin
                                tk.kind   = dmfp_pkg::TK_RDLEN;
                                nx.rdleft = v16;
                                if (v16 == 16'd0) begin
                                    nx.rleft = (st.rleft != 18'd0) ? st.rleft - 18'd1 : 18'd0;
                                    nx.rcnt  = st.rcnt + 18'd1;
                                    nx.phase = (nx.rleft != 18'd0) ? dmfp_pkg::PH_RN_LEN
                                                                   : dmfp_pkg::PH_TRAIL;
                                end else if (st.rtype == dmfp_pkg::TypeMx && v16 > 16'd3) begin
                                    nx.phase = dmfp_pkg::PH_MXPREF;
                                    nx.fbl   = 3'd2;
                                    nx.acc   = '0;
                                end else if (st.rtype == dmfp_pkg::TypeCname) begin
                                    nx.phase = dmfp_pkg::PH_DN_LEN;
                                end else begin
                                    nx.phase = dmfp_pkg::PH_RDRAW;
                                end
                            end
                            default: begin
                                tk.kind  = dmfp_pkg::TK_MXPREF;
                                nx.phase = dmfp_pkg::PH_DN_LEN;
                            end
                        endcase
                    end
                end
                dmfp_pkg::PH_RDRAW: begin
                    in_rd     = 1'b1;
                    nx.rdleft = rdl;
                    have      = 1'b1;
                    tk.kind   = dmfp_pkg::TK_RDATA;
                    tk.value  = {24'd0, b};
                    tk.sec    = 2'd2;
                end
                default: begin
                    if (st.leftover != 10'd1023) nx.leftover = st.leftover + 10'd1;
                end
            endcase
            // close the record once its rdata is used up
            if (in_rd && nx.rdleft == 16'd0) begin
                nx.rleft = (st.rleft != 18'd0) ? st.rleft - 18'd1 : 18'd0;
                nx.rcnt  = st.rcnt + 18'd1;
                nx.phase = (nx.rleft != 18'd0) ? dmfp_pkg::PH_RN_LEN : dmfp_pkg::PH_TRAIL;
            end
        end

        // emit tokens
        n  = have ? 2'd1 : 2'd0;
        t0 = tk;
        t1 = '0;
        t1.off = st.pos;
        if (stop_now && !(last && st.pos < 10'd11)) begin
            t1.kind = dmfp_pkg::TK_END;
            n = 2'd2;
        end
        if (st.pos < PosCap) nx.pos = st.pos + 10'd1;
        if (last) begin
            if (st.pos < 10'd11) begin
                t1.kind  = dmfp_pkg::TK_ERROR;
                t1.value = dmfp_pkg::ErrTooShort;
                n = n + 2'd1;
            end else if (nx.stopped) begin
                n = n;
            end else if (nx.phase == dmfp_pkg::PH_TRAIL) begin
                t1.kind  = dmfp_pkg::TK_END;
                t1.value = {22'd0, nx.leftover};
                n = n + 2'd1;
            end else begin
                t1.kind  = dmfp_pkg::TK_ERROR;
                t1.value = dmfp_pkg::ErrTruncated;
                n = n + 2'd1;
            end
            nx = '0;
        end
        // a single token sits in slot zero
        if (!have) t0 = t1;
    end

endmodule

@@ sv/dns_message_field_parser.sv @@
// ----------------------------------------------------------------------------
// dns_message_field_parser
// Byte-serial DNS message tokenizer with a two-entry result queue.
// ----------------------------------------------------------------------------
// A token appears on m_ in the cycle after its byte is taken.
// Throughput: one byte per cycle while m_ready stays high; a byte making two
// tokens holds s_ready low while the queue holds both.
// Reset: synchronous, active-low aresetn returns the parse state to header
// start and empties the result queue.
module dns_message_field_parser #(
    parameter int MSG_MAX = dmfp_pkg::MsgMaxDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_msg_byte,
    input  logic        s_msg_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_token_kind,
    output logic [31:0] m_token_value,
    output logic [17:0] m_record_number,
    output logic [1:0]  m_section,
    output logic [9:0]  m_byte_offset,
    output logic        m_last_of_run
);

    localparam int CapInt = (MSG_MAX - 1 < 1023) ? MSG_MAX - 1 : 1023;
    localparam logic [9:0] PosCap = 10'(CapInt);

    dmfp_pkg::pstate_t st_reg, st_next;
    dmfp_pkg::token_t  t0, t1;
    logic [1:0]        n;

    dmfp_pkg::token_t  q_reg [2];
    logic              ql_reg [2];
    logic [1:0]        cnt_reg;
    logic              acc_in, pop;

    dmfp_step #(.PosCap(PosCap)) u_step (
        .st  (st_reg),
        .b   (s_msg_byte),
        .last(s_msg_last),
        .nx  (st_next),
        .n   (n),
        .t0  (t0),
        .t1  (t1)
    );

    assign pop     = m_valid && m_ready;
    // room for two tokens after this cycle's pop
    assign s_ready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && pop);
    assign acc_in  = s_valid && s_ready;
    assign m_valid = cnt_reg != 2'd0;

    assign m_token_kind    = q_reg[0].kind;
    assign m_token_value   = q_reg[0].value;
    assign m_record_number = q_reg[0].rec;
    assign m_section       = q_reg[0].sec;
    assign m_byte_offset   = q_reg[0].off;
    assign m_last_of_run   = ql_reg[0];

    // advance parse state on each byte transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else if (acc_in) begin
            st_reg <= st_next;
        end
    end

    // load tokens into the queue, shift on transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else if (acc_in) begin
            cnt_reg   <= n;
            q_reg[0]  <= t0;
            ql_reg[0] <= (n == 2'd1);
            q_reg[1]  <= t1;
            ql_reg[1] <= 1'b1;
        end else if (pop) begin
            cnt_reg   <= cnt_reg - 2'd1;
            q_reg[0]  <= q_reg[1];
            ql_reg[0] <= ql_reg[1];
        end
    end

endmodule

@@ tb/sv/dns_message_field_parser_test.sv @@
// ----------------------------------------------------------------------------
// dns_message_field_parser_test
// Feeds DNS messages byte by byte into the parser, predicts every token with
// an internal model of the parse state, and compares the token stream.
// ----------------------------------------------------------------------------
module dns_message_field_parser_test;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
    } msg_byte_t;

    typedef struct packed {
        logic [4:0]  kind;
        logic [31:0] value;
        logic [17:0] rec;
        logic [1:0]  sec;
        logic [9:0]  off;
        logic        lor;
    } tok_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_msg_byte;
    logic        s_msg_last;
    logic        m_valid;
    logic        m_ready;
    logic [4:0]  m_token_kind;
    logic [31:0] m_token_value;
    logic [17:0] m_record_number;
    logic [1:0]  m_section;
    logic [9:0]  m_byte_offset;
    logic        m_last_of_run;

    dns_message_field_parser dut (.*);

    msg_byte_t pending_bytes[$];
    tok_t      expected_tokens[$];
    int        mismatch_count;
    int        cycle_count;
    bit        stimulus_done;
    bit        calm_mode;
    int        hold_off_left;
    logic      s_ready_seen;

    // parser model state
    dmfp_pkg::phase_t ph;
    logic [9:0]  pos;
    logic [31:0] acc;
    logic [2:0]  fbl;
    logic [15:0] qleft;
    logic [17:0] rleft;
    logic [17:0] rcnt;
    logic [7:0]  lbl;
    logic [15:0] rtype;
    logic [15:0] rdleft;
    logic        stopped;
    logic [9:0]  leftover;
    tok_t        run_toks[$];

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic void clear_parse();
        ph = dmfp_pkg::PH_HDR; pos = '0; acc = '0; fbl = '0; qleft = '0; rleft = '0;
        rcnt = '0; lbl = '0; rtype = '0; rdleft = '0; stopped = 1'b0; leftover = '0;
    endfunction

    function automatic void emit(dmfp_pkg::token_kind_t k, logic [31:0] v,
                                 logic [17:0] r, logic [1:0] s, logic [9:0] o);
        tok_t t;
        if (run_toks.size() >= 2) return;
        t = '{kind: k, value: v, rec: r, sec: s, off: o, lor: 1'b0};
        run_toks.push_back(t);
    endfunction

    function automatic void enter_field(dmfp_pkg::phase_t p, logic [2:0] n);
        ph = p; fbl = n; acc = '0;
    endfunction

    function automatic void begin_records();
        rcnt = '0;
        ph = (rleft != 18'd0) ? dmfp_pkg::PH_RN_LEN : dmfp_pkg::PH_TRAIL;
    endfunction

    function automatic void close_record();
        if (rleft != 18'd0) rleft--;
        rcnt++;
        ph = (rleft != 18'd0) ? dmfp_pkg::PH_RN_LEN : dmfp_pkg::PH_TRAIL;
    endfunction

    function automatic void name_finished(int ctx);
        if (ctx == 0) enter_field(dmfp_pkg::PH_QTYPE, 3'd2);
        else if (ctx == 1) enter_field(dmfp_pkg::PH_RTYPE, 3'd2);
        else ph = dmfp_pkg::PH_RDRAW;
    endfunction

    // Predict the tokens caused by one message byte and queue them.
    function automatic void predict_tokens(logic [7:0] b, logic last);
        logic [9:0]  p;
        logic [17:0] r;
        logic        in_rd, stop_now;
        logic [15:0] v16;
        int          ctx, sub;
        dmfp_pkg::phase_t base;
        logic [1:0]  sec;
        p = pos; r = rcnt; in_rd = 1'b0; stop_now = 1'b0;
        run_toks.delete();
        if (!stopped) begin
            if (ph == dmfp_pkg::PH_HDR) begin
                if (!p[0]) begin
                    acc = 32'(b);
                end else begin
                    v16 = {acc[7:0], b};
                    if (p == 10'd1) emit(dmfp_pkg::TK_ID, 32'(v16), 18'd0, 2'd0, p);
                    else if (p == 10'd3) begin
                        emit(dmfp_pkg::TK_FLAGS, 32'(v16), 18'd0, 2'd0, p);
                        if (acc[7] && b[2:0] != 3'd0) begin
                            stopped = 1'b1; stop_now = 1'b1;
                        end
                    end else begin
                        emit(dmfp_pkg::token_kind_t'(5'(dmfp_pkg::TK_QDCOUNT + (p - 10'd5) / 2)),
                             32'(v16), 18'd0, 2'd0, p);
                        if (p == 10'd5) qleft = v16;
                        else rleft = rleft + 18'(v16);
                        if (p == 10'd11) begin
                            rcnt = '0;
                            if (qleft != 16'd0) ph = dmfp_pkg::PH_QN_LEN;
                            else begin_records();
                        end
                    end
                end
            end else if (ph >= dmfp_pkg::PH_QN_LEN && ph < dmfp_pkg::PH_QTYPE) begin
                ctx = (ph - dmfp_pkg::PH_QN_LEN) / 3;
                sub = (ph - dmfp_pkg::PH_QN_LEN) % 3;
                base = dmfp_pkg::phase_t'(5'(dmfp_pkg::PH_QN_LEN + 3 * ctx));
                sec = 2'(ctx + 1);
                if (ctx == 2) begin
                    in_rd = 1'b1;
                    if (rdleft != 16'd0) rdleft--;
                end
                if (sub == 0) begin
                    if (b[7:6] == 2'b11) begin
                        acc = 32'(b[5:0]);
                        ph = dmfp_pkg::phase_t'(5'(base + 2));
                    end else if (b == 8'd0) begin
                        emit(dmfp_pkg::TK_NAMEEND, 32'd0, r, sec, p);
                        name_finished(ctx);
                    end else begin
                        emit(dmfp_pkg::TK_LABELLEN, 32'(b), r, sec, p);
                        lbl = b;
                        ph = dmfp_pkg::phase_t'(5'(base + 1));
                    end
                end else if (sub == 1) begin
                    emit(dmfp_pkg::TK_CHAR, 32'(b), r, sec, p);
                    if (lbl != 8'd0) lbl--;
                    if (lbl == 8'd0) ph = base;
                end else begin
                    emit(dmfp_pkg::TK_POINTER, 32'({acc[5:0], b}), r, sec, p);
                    name_finished(ctx);
                end
            end else if (ph >= dmfp_pkg::PH_QTYPE && ph <= dmfp_pkg::PH_MXPREF) begin
                if (ph == dmfp_pkg::PH_MXPREF) begin
                    in_rd = 1'b1;
                    if (rdleft != 16'd0) rdleft--;
                end
                acc = {acc[23:0], b};
                if (fbl != 3'd0) fbl--;
                if (fbl == 3'd0) begin
                    v16 = acc[15:0];
                    case (ph)
                        dmfp_pkg::PH_QTYPE: begin
                            emit(dmfp_pkg::TK_TYPE, 32'(v16), r, 2'd1, p);
                            enter_field(dmfp_pkg::PH_QCLASS, 3'd2);
                        end
                        dmfp_pkg::PH_QCLASS: begin
                            emit(dmfp_pkg::TK_CLASS, 32'(v16), r, 2'd1, p);
                            if (qleft != 16'd0) qleft--;
                            rcnt++;
                            if (qleft != 16'd0) ph = dmfp_pkg::PH_QN_LEN;
                            else begin_records();
                        end
                        dmfp_pkg::PH_RTYPE: begin
                            emit(dmfp_pkg::TK_TYPE, 32'(v16), r, 2'd2, p);
                            rtype = v16;
                            enter_field(dmfp_pkg::PH_RCLASS, 3'd2);
                        end
                        dmfp_pkg::PH_RCLASS: begin
                            emit(dmfp_pkg::TK_CLASS, 32'(v16), r, 2'd2, p);
                            enter_field(dmfp_pkg::PH_TTL, 3'd4);
                        end
                        dmfp_pkg::PH_TTL: begin
                            emit(dmfp_pkg::TK_TTL, acc, r, 2'd2, p);
                            enter_field(dmfp_pkg::PH_RDLEN, 3'd2);
                        end
                        dmfp_pkg::PH_RDLEN: begin
                            emit(dmfp_pkg::TK_RDLEN, 32'(v16), r, 2'd2, p);
                            rdleft = v16;
                            if (v16 == 16'd0) close_record();
                            else if (rtype == dmfp_pkg::TypeMx && v16 > 16'd3)
                                enter_field(dmfp_pkg::PH_MXPREF, 3'd2);
                            else if (rtype == dmfp_pkg::TypeCname) ph = dmfp_pkg::PH_DN_LEN;
                            else ph = dmfp_pkg::PH_RDRAW;
                        end
                        default: begin
                            emit(dmfp_pkg::TK_MXPREF, 32'(v16), r, 2'd2, p);
                            ph = dmfp_pkg::PH_DN_LEN;
                        end
                    endcase
                end
            end else if (ph == dmfp_pkg::PH_RDRAW) begin
                in_rd = 1'b1;
                if (rdleft != 16'd0) rdleft--;
                emit(dmfp_pkg::TK_RDATA, 32'(b), r, 2'd2, p);
            end else begin
                if (leftover < 10'd1023) leftover++;
            end
            if (in_rd && rdleft == 16'd0) close_record();
        end
        if (stop_now && !(last && p < 10'd11))
            emit(dmfp_pkg::TK_END, 32'd0, 18'd0, 2'd0, p);
        if (pos < 10'd1023) pos++;
        if (last) begin
            if (p < 10'd11) emit(dmfp_pkg::TK_ERROR, dmfp_pkg::ErrTooShort, 18'd0, 2'd0, p);
            else if (stopped) begin
                // end token already reported with the flags
            end else if (ph == dmfp_pkg::PH_TRAIL)
                emit(dmfp_pkg::TK_END, 32'(leftover), 18'd0, 2'd0, p);
            else emit(dmfp_pkg::TK_ERROR, dmfp_pkg::ErrTruncated, 18'd0, 2'd0, p);
            clear_parse();
        end
        if (run_toks.size() > 0) run_toks[run_toks.size() - 1].lor = 1'b1;
        foreach (run_toks[i]) expected_tokens.push_back(run_toks[i]);
    endfunction

    // Message building helpers
    function automatic void put_byte(logic [7:0] b, logic last = 1'b0);
        pending_bytes.push_back('{b: b, last: last});
    endfunction

    function automatic void put16(logic [15:0] v);
        put_byte(v[15:8]); put_byte(v[7:0]);
    endfunction

    function automatic void put_name(bit allow_ptr);
        int nl;
        int ln;
        nl = $urandom_range(0, 3);
        repeat (nl) begin
            ln = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 191) % 70 + 1
                                             : $urandom_range(1, 6);
            put_byte(8'(ln));
            repeat (ln) put_byte(8'($urandom_range(0, 255)));
        end
        if (allow_ptr && $urandom_range(0, 2) == 0) begin
            put_byte(8'hC0 | 8'($urandom_range(0, 63)));
            put_byte(8'($urandom_range(0, 255)));
        end else begin
            put_byte(8'h00);
        end
    endfunction

    // Append a mostly well-formed message; sometimes cut or padded.
    function automatic void put_message();
        int qd, an, ns, ar, start, n, rdl;
        logic [15:0] fl, rt;
        qd = $urandom_range(0, 2); an = $urandom_range(0, 2);
        ns = $urandom_range(0, 1); ar = $urandom_range(0, 1);
        fl = 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 4) != 0) fl[2:0] = 3'd0;
        start = pending_bytes.size();
        put16(16'($urandom_range(0, 65535))); put16(fl);
        put16(16'(qd)); put16(16'(an)); put16(16'(ns)); put16(16'(ar));
        repeat (qd) begin
            put_name(1);
            put16(16'($urandom_range(0, 65535))); put16(16'($urandom_range(0, 65535)));
        end
        repeat (an + ns + ar) begin
            put_name(1);
            case ($urandom_range(0, 3))
                0: rt = dmfp_pkg::TypeMx;
                1: rt = dmfp_pkg::TypeCname;
                default: rt = 16'($urandom_range(0, 65535));
            endcase
            put16(rt); put16(16'($urandom_range(0, 65535)));
            put16(16'($urandom_range(0, 65535))); put16(16'($urandom_range(0, 65535)));
            rdl = $urandom_range(0, 12);
            put16(16'(rdl));
            repeat (rdl) put_byte(8'($urandom_range(0, 255)));
        end
        repeat ($urandom_range(0, 3)) put_byte(8'($urandom_range(0, 255)));
        n = pending_bytes.size() - start;
        if ($urandom_range(0, 7) == 0) begin
            // truncate at a random point
            n = $urandom_range(1, n);
            while (pending_bytes.size() > start + n) void'(pending_bytes.pop_back());
        end
        pending_bytes[pending_bytes.size() - 1].last = 1'b1;
    endfunction

    // Directed messages covering header extremes and the special cases
    task automatic directed_messages();
        // too short: single byte, then ten bytes
        put_byte(8'hFF, 1'b1);
        repeat (9) put_byte(8'h00);
        put_byte(8'hFF, 1'b1);
        // error rcode response, then extra bytes
        put16(16'hFFFF); put16(16'h8183); put16(16'd0); put16(16'd0); put16(16'd0);
        put16(16'd0);
        put_byte(8'hAA); put_byte(8'h55, 1'b1);
        // no records, leftover bytes
        put16(16'h0000); put16(16'h0000); put16(16'd0); put16(16'd0); put16(16'd0);
        put16(16'd0);
        put_byte(8'h00); put_byte(8'hFF, 1'b1);
        // one question with pointer, MX record, CNAME overrunning rdata
        put16(16'h1234); put16(16'h0100); put16(16'd1); put16(16'd1); put16(16'd1);
        put16(16'd0);
        put_byte(8'hC0); put_byte(8'h0C); put16(16'h000F); put16(16'h0001);
        put_byte(8'h00); put16(dmfp_pkg::TypeMx); put16(16'd1); put16(16'hFFFF);
        put16(16'hFFFF);
        put16(16'd6); put16(16'h000A); put_byte(8'h41); put_byte(8'h61);
        put_byte(8'h00); put_byte(8'h7E);
        put_byte(8'h00); put16(dmfp_pkg::TypeCname); put16(16'd1); put16(16'd0);
        put16(16'd0); put16(16'd2);
        put_byte(8'h05); put_byte(8'h62, 1'b1);
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_msg_byte = 8'h00;
        s_msg_last = 1'b0;
        m_ready = 1'b0;
        mismatch_count = 0;
        cycle_count = 0;
        stimulus_done = 1'b0;
        calm_mode = 1'b0;
        hold_off_left = 0;
        clear_parse();
        directed_messages();
        while (pending_bytes.size() < 150) put_message();
        // a long message to reach the offset and leftover caps, then more
        put16(16'd0); put16(16'd0); put16(16'd0); put16(16'd0); put16(16'd0);
        put16(16'd0);
        repeat (1030) put_byte(8'($urandom_range(0, 255)));
        put_byte(8'h00, 1'b1);
        put_message();
        put_message();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
    end

    // Driver: present bytes at the falling edge, idling at random.
    always @(negedge aclk) begin
        if (aresetn) begin
            calm_mode <= (cycle_count > 900 && cycle_count < 1500);
            if (!s_valid || s_ready_seen) begin
                if (pending_bytes.size() > 0 &&
                    (calm_mode || $urandom_range(0, 99) >= 34)) begin
                    s_msg_byte <= pending_bytes[0].b;
                    s_msg_last <= pending_bytes[0].last;
                    s_valid <= 1'b1;
                    void'(pending_bytes.pop_front());
                end else begin
                    s_valid <= 1'b0;
                    if (pending_bytes.size() == 0) stimulus_done <= 1'b1;
                end
            end
            // receiver idles at random, and throughout a hold-off
            m_ready <= (hold_off_left == 0) && (calm_mode || $urandom_range(0, 99) >= 34);
        end
    end

    // Receiver hold-off: count down one long stretch of stalls
    always @(negedge aclk) begin
        if (aresetn) begin
            if (cycle_count == 300) hold_off_left <= 300;
            else if (hold_off_left > 0) hold_off_left <= hold_off_left - 1;
        end
    end

    // Transfer seen at the last rising edge on the input side
    always @(posedge aclk) begin
        s_ready_seen <= s_valid && s_ready && aresetn;
        if (aresetn && s_valid && s_ready) predict_tokens(s_msg_byte, s_msg_last);
    end

    // Monitor: compare each token transfer with the oldest prediction.
    always @(posedge aclk) begin
        tok_t want;
        if (aresetn) begin
            cycle_count <= cycle_count + 1;
            if (m_valid && m_ready) begin
                if (expected_tokens.size() == 0) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display("unexpected token kind %0d value %0h at offset %0d",
                                 m_token_kind, m_token_value, m_byte_offset);
                end else begin
                    want = expected_tokens.pop_front();
                    if (m_token_kind !== want.kind || m_token_value !== want.value ||
                        m_record_number !== want.rec || m_section !== want.sec ||
                        m_byte_offset !== want.off || m_last_of_run !== want.lor) begin
                        mismatch_count <= mismatch_count + 1;
                        if (mismatch_count < 10)
                            $display({"token mismatch: exp %0d/%0h/%0d/%0d/%0d/%0b",
                                      " got %0d/%0h/%0d/%0d/%0d/%0b"},
                                     want.kind, want.value, want.rec, want.sec,
                                     want.off, want.lor,
                                     m_token_kind, m_token_value, m_record_number,
                                     m_section, m_byte_offset, m_last_of_run);
                    end
                end
            end
        end
    end

    // End of run
    initial begin
        wait (aresetn);
        fork
            begin
                wait (stimulus_done && !s_valid && expected_tokens.size() == 0);
                repeat (20) @(posedge aclk);
                if (mismatch_count == 0 && expected_tokens.size() == 0) $display("TB_OK");
                else $display("TB_ERROR");
                $finish;
            end
            begin
                wait (cycle_count >= 200000);
                $display("TB_ERROR");
                $finish;
            end
        join
    end

endmodule
